/* src/fhbd_pkg.sv */
`timescale 1ns / 1ps

package fhbd_pkg;

  // default sizes of the history store and the energy datapath
  localparam int unsigned HISTORY_DEPTH_DEF = 8;
  localparam int unsigned MAX_TONES_DEF     = 8;
  localparam int unsigned ENERGY_WIDTH_DEF  = 32;

  // fixed field widths
  localparam int unsigned POS_W       = 16;
  localparam int unsigned TONE_CNT_W  = 4;
  localparam int unsigned THRESH_W    = 16;
  localparam int unsigned THRESH_FRAC = 12;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned DIVISOR_W_DEF = 7;

  // register reset values
  localparam logic                  HISTORY_MODE_RST = 1'b0;
  localparam logic [TONE_CNT_W-1:0] TONE_COUNT_RST   = 4'd1;
  localparam logic [THRESH_W-1:0]   THRESH_RST       = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HISTORY_MODE = 2'd0,
    CFG_TONE_COUNT   = 2'd1,
    CFG_SHIFT_THRESH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* src/fhbd_in_if.sv */
`timescale 1ns / 1ps

interface fhbd_in_if import fhbd_pkg::*; #(
  parameter int unsigned EnergyWidth = ENERGY_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [EnergyWidth-1:0] energy_low_tone;
  logic [EnergyWidth-1:0] energy_high_tone;
  logic [POS_W-1:0]       bit_position;

  modport source (
    output valid, energy_low_tone, energy_high_tone, bit_position,
    input  ready
  );
  modport sink (
    input  valid, energy_low_tone, energy_high_tone, bit_position,
    output ready
  );
endinterface

/* src/fhbd_out_if.sv */
`timescale 1ns / 1ps

interface fhbd_out_if;
  logic valid;
  logic ready;
  logic decided_bit;
  logic was_overridden;

  modport source (
    output valid, decided_bit, was_overridden,
    input  ready
  );
  modport sink (
    input  valid, decided_bit, was_overridden,
    output ready
  );
endinterface

/* src/fhbd_divider.sv */
`timescale 1ns / 1ps

module fhbd_divider import fhbd_pkg::*; #(
  parameter int unsigned DivisorWidth  = DIVISOR_W_DEF,
  parameter int unsigned DividendWidth = POS_W
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DividendWidth-1:0] dividend_i,
  input  logic [DivisorWidth-1:0]  divisor_i,
  output logic [DividendWidth-1:0] quotient_o,
  output logic [DivisorWidth-1:0]  remainder_o,
  output div_status_t              status_o
);

  localparam int unsigned CntW = $clog2(DividendWidth);

  logic [DividendWidth-1:0] quo_q;
  logic [DivisorWidth-1:0]  rem_q;
  logic [DivisorWidth-1:0]  dsr_q;
  logic [CntW-1:0]          cnt_q;
  logic                     busy_q;
  logic                     done_q;

  logic [DivisorWidth:0] trial;
  logic [DivisorWidth:0] diff;
  logic                  take;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[DividendWidth-1]};
    diff  = trial - {1'b0, dsr_q};
    take  = trial >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DividendWidth - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[DivisorWidth-1:0] : trial[DivisorWidth-1:0];
      quo_q <= {quo_q[DividendWidth-2:0], take};
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign status_o    = '{busy: busy_q, done: done_q};

endmodule

/* src/fsk_history_bit_decision.sv */
`timescale 1ns / 1ps
// plain mode: the result goes through the finish state to the output register
// history mode: a 16-step pass of the divider for the tone slot, a row step, history
//   read, shift check and store, then the finish state
// first round or failed ratio gate: read and check are skipped
// items are taken only in idle; a result waiting at the output holds the finish state
// reset (async, active low) clears control and config; the history store is not cleared
module fsk_history_bit_decision import fhbd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned MAX_TONES     = MAX_TONES_DEF,
  parameter int unsigned ENERGY_WIDTH  = ENERGY_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fhbd_in_if.sink               in_i,
  fhbd_out_if.source            out_o
);

  localparam int unsigned EW      = ENERGY_WIDTH;
  localparam int unsigned DW      = $clog2(MAX_TONES + 1);
  localparam int unsigned RW      = $clog2(HISTORY_DEPTH);
  localparam int unsigned TW      = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int unsigned Depth   = HISTORY_DEPTH * MAX_TONES;
  localparam int unsigned AW      = $clog2(Depth);
  localparam int unsigned AccW    = EW + THRESH_W;
  localparam int unsigned GW      = EW + 5;
  localparam int unsigned SumW    = EW + 1;
  localparam int unsigned MulCntW = $clog2(THRESH_W);
  localparam int unsigned RowShift = POS_W + $clog2(HISTORY_DEPTH);
  localparam int unsigned RecipW   = POS_W + 1;
  localparam int unsigned ProdW    = POS_W + RecipW;
  // ceil(2^RowShift / HISTORY_DEPTH), exact quotient for every 16-bit round
  localparam longint unsigned RowRecip =
    ((64'd1 << RowShift) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TONE,
    ST_DIV_ROW,
    ST_READ,
    ST_DIFF,
    ST_CHECK,
    ST_STORE,
    ST_FINISH
  } state_e;

  state_e state_q;

  // configuration
  logic                  history_mode_q;
  logic [TONE_CNT_W-1:0] tone_count_q;
  logic [THRESH_W-1:0]   shift_threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      history_mode_q    <= HISTORY_MODE_RST;
      tone_count_q      <= TONE_COUNT_RST;
      shift_threshold_q <= THRESH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HISTORY_MODE: history_mode_q    <= cfg_data_i[0];
        CFG_TONE_COUNT:   tone_count_q      <= cfg_data_i[TONE_CNT_W-1:0];
        CFG_SHIFT_THRESH: shift_threshold_q <= cfg_data_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  logic [EW-1:0]       e0_q, e1_q, big_q;
  logic                amp_bit_q, bit_q;
  logic                gate_q, round_nz_q;
  logic [TW-1:0]       tone_q;
  logic [POS_W-1:0]    rq_q;
  logic [RW-1:0]       row_q, prev_row_q;
  logic [EW-1:0]       ad0_q, ad1_q;
  logic                up0_q, up1_q;
  logic [AccW-1:0]     acc_q;
  logic [THRESH_W-1:0] thr_sh_q;
  logic                mul_busy_q;
  logic [MulCntW-1:0]  mul_cnt_q;
  logic [2*EW-1:0]     rd_data_q;
  logic [2*EW-1:0]     hist_mem_q [Depth];
  logic                out_valid_q, out_bit_q, out_ovr_q;

  logic in_acc;
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // effective tone count, clamped to 1..MAX_TONES
  logic [7:0]    tc_ext;
  logic [DW-1:0] tones_eff;
  always_comb begin
    tc_ext = {4'b0, tone_count_q};
    if (tone_count_q == '0) begin
      tones_eff = DW'(1);
    end else if (tc_ext > 8'(MAX_TONES)) begin
      tones_eff = DW'(MAX_TONES);
    end else begin
      tones_eff = DW'(tone_count_q);
    end
  end

  // divider: bit_position / tones
  logic             div_start;
  logic [POS_W-1:0] div_dividend;
  logic [DW-1:0]    div_divisor;
  logic [POS_W-1:0] div_quo;
  logic [DW-1:0]    div_rem;
  div_status_t      div_st;

  assign div_start    = in_acc && history_mode_q;
  assign div_dividend = in_i.bit_position;
  assign div_divisor  = tones_eff;

  fhbd_divider #(
    .DivisorWidth (DW),
    .DividendWidth(POS_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .remainder_o(div_rem),
    .status_o   (div_st)
  );

  // ratio gate: 4*e0 < 25*e1 and 4*e1 < 25*e0
  logic [GW-1:0] e0x25, e1x25;
  logic          gate_c;
  always_comb begin
    e0x25  = (GW'(e0_q) << 4) + (GW'(e0_q) << 3) + GW'(e0_q);
    e1x25  = (GW'(e1_q) << 4) + (GW'(e1_q) << 3) + GW'(e1_q);
    gate_c = (GW'(e0_q) << 2 < e1x25) && (GW'(e1_q) << 2 < e0x25);
  end

  // round mod HISTORY_DEPTH by reciprocal multiply, quotient registered first
  logic [ProdW-1:0] round_prod;
  logic [POS_W-1:0] rq_c, rq_mul, round_rem;
  logic [RW-1:0]    row_c, prev_row_c;
  always_comb begin
    round_prod = ProdW'(div_quo) * ProdW'(RowRecip);
    rq_c       = POS_W'(round_prod >> RowShift);
    rq_mul     = rq_q * POS_W'(HISTORY_DEPTH);
    round_rem  = div_quo - rq_mul;
    row_c      = round_rem[RW-1:0];
    prev_row_c = (row_c == '0) ? RW'(HISTORY_DEPTH - 1) : row_c - 1'b1;
  end

  logic [EW-1:0] p0, p1;
  assign p0 = rd_data_q[EW-1:0];
  assign p1 = rd_data_q[2*EW-1:EW];

  logic [SumW-1:0] sum_c;
  logic            signif;
  always_comb begin
    sum_c  = SumW'(ad0_q) + SumW'(ad1_q);
    signif = (AccW'(sum_c) << THRESH_FRAC) > acc_q;
  end

  logic [AW-1:0] rd_addr, wr_addr;
  assign rd_addr = AW'(prev_row_q) * AW'(MAX_TONES) + AW'(tone_q);
  assign wr_addr = AW'(row_q) * AW'(MAX_TONES) + AW'(tone_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e0_q      <= in_i.energy_low_tone;
      e1_q      <= in_i.energy_high_tone;
      big_q     <= (in_i.energy_low_tone > in_i.energy_high_tone) ?
                   in_i.energy_low_tone : in_i.energy_high_tone;
      amp_bit_q <= !(in_i.energy_low_tone > in_i.energy_high_tone);
      bit_q     <= !(in_i.energy_low_tone > in_i.energy_high_tone);
    end
    // threshold * max energy, shift-add over the threshold bits, msb first
    if (in_acc) begin
      acc_q    <= '0;
      thr_sh_q <= shift_threshold_q;
    end else if (mul_busy_q) begin
      acc_q    <= (acc_q << 1) + (thr_sh_q[THRESH_W-1] ? AccW'(big_q) : '0);
      thr_sh_q <= thr_sh_q << 1;
    end
    if (state_q == ST_DIV_TONE) begin
      gate_q <= gate_c;
      if (div_st.done) begin
        tone_q     <= div_rem[TW-1:0];
        round_nz_q <= |div_quo;
        rq_q       <= rq_c;
      end
    end
    if (state_q == ST_DIV_ROW) begin
      row_q      <= row_c;
      prev_row_q <= prev_row_c;
    end
    if (state_q == ST_DIFF) begin
      up0_q <= e0_q > p0;
      up1_q <= e1_q > p1;
      ad0_q <= (e0_q > p0) ? e0_q - p0 : p0 - e0_q;
      ad1_q <= (e1_q > p1) ? e1_q - p1 : p1 - e1_q;
    end
    if (state_q == ST_CHECK) begin
      if (signif && up0_q && !up1_q) begin
        bit_q <= 1'b0;
      end else if (signif && !up0_q && up1_q) begin
        bit_q <= 1'b1;
      end
    end
  end

  // history store
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rd_data_q <= hist_mem_q[rd_addr];
    end
    if (state_q == ST_STORE) begin
      hist_mem_q[wr_addr] <= {e1_q, e0_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
      mul_cnt_q  <= '0;
    end else if (in_acc && history_mode_q) begin
      mul_busy_q <= 1'b1;
      mul_cnt_q  <= MulCntW'(THRESH_W - 1);
    end else if (mul_busy_q) begin
      if (mul_cnt_q == '0) begin
        mul_busy_q <= 1'b0;
      end else begin
        mul_cnt_q <= mul_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_bit_q   <= 1'b0;
      out_ovr_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= history_mode_q ? ST_DIV_TONE : ST_FINISH;
          end
        end
        ST_DIV_TONE: begin
          if (div_st.done) begin
            state_q <= ST_DIV_ROW;
          end
        end
        ST_DIV_ROW: state_q <= (round_nz_q && gate_q) ? ST_READ : ST_STORE;
        ST_READ:    state_q <= ST_DIFF;
        ST_DIFF:    state_q <= ST_CHECK;
        ST_CHECK:   state_q <= ST_STORE;
        ST_STORE:   state_q <= ST_FINISH;
        ST_FINISH: begin
          // hold the result until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_bit_q   <= bit_q;
            out_ovr_q   <= bit_q ^ amp_bit_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.decided_bit    = out_bit_q;
  assign out_o.was_overridden = out_ovr_q;

  a_ovr_needs_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ovr_q |-> history_mode_q)
    else $error("override flagged outside history mode");

  a_mul_done_before_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> !mul_busy_q)
    else $error("threshold product not ready at significance check");

  a_prev_row_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> prev_row_q != row_q)
    else $error("history read hits the row about to be written");

  a_div_only_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_st.busy || div_st.done) |-> state_q == ST_DIV_TONE)
    else $error("divider active outside its sequencer state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("transaction accepted but sequencer stayed idle");

endmodule
